// ===== rtl/bhm_pkg.sv =====
`timescale 1ns / 1ps
package bhm_pkg;

   localparam int REG_BITS   = 24;
   localparam int COLOR_BITS = 24;
   localparam int INDEX_BITS = 3;
   localparam int FLASH_BITS = 3;
   localparam int AWB_BITS   = 2;
   localparam int CSR_IDX_BITS = 2;
   localparam int REQ_DATA_BITS = 8;
   localparam int RSP_DATA_BITS = 40;

   localparam logic [CSR_IDX_BITS-1:0] CSR_HOLD  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STEP  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ABORT = 2'd2;

   localparam logic [REG_BITS-1:0] HOLD_RESET  = 24'd1250000;
   localparam logic [REG_BITS-1:0] STEP_RESET  = 24'd1000000;
   localparam logic [REG_BITS-1:0] ABORT_RESET = 24'd15000000;

   localparam logic [AWB_BITS-1:0] AWB_NONE    = 2'd0;
   localparam logic [AWB_BITS-1:0] AWB_ENABLE  = 2'd1;
   localparam logic [AWB_BITS-1:0] AWB_DISABLE = 2'd2;

   localparam logic [FLASH_BITS-1:0] FLASH_NONE    = 3'd0;
   localparam logic [FLASH_BITS-1:0] FLASH_CONFIRM = 3'd3;
   localparam logic [FLASH_BITS-1:0] FLASH_FINISH  = 3'd4;

   localparam logic [COLOR_BITS-1:0] COLOR_OFF  = 24'h000000;
   localparam logic [COLOR_BITS-1:0] COLOR_BLUE = 24'h0000ff;

   typedef struct packed {
      logic [REG_BITS-1:0] hold_ticks;
      logic [REG_BITS-1:0] step_ticks;
      logic [REG_BITS-1:0] abort_ticks;
   } cfg_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0] menu_index;
      logic                  pipe_active;
      logic [AWB_BITS-1:0]   awb_cmd;
      logic [FLASH_BITS-1:0] flash_count;
      logic [COLOR_BITS-1:0] led_color;
      logic                  led_write;
   } result_type;

   function automatic logic [COLOR_BITS-1:0] index_color(input logic [INDEX_BITS-1:0] idx);
      logic [COLOR_BITS-1:0] c;
      case (idx)
         3'd0:    c = 24'hffffff;
         3'd1:    c = 24'hff0000;
         3'd2:    c = 24'hffa000;
         3'd3:    c = 24'hffff00;
         3'd4:    c = 24'h00ff00;
         3'd5:    c = 24'h00ffff;
         3'd6:    c = 24'h0000ff;
         default: c = 24'hff00ff;
      endcase
      return c;
   endfunction

endpackage

// ===== rtl/bhm_csr.sv =====
`timescale 1ns / 1ps
module bhm_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [bhm_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [bhm_pkg::REG_BITS-1:0]       csr_wdata,
   output bhm_pkg::cfg_type                   cfg
);
   import bhm_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_HOLD:  cfg_in.hold_ticks  = csr_wdata;
            CSR_STEP:  cfg_in.step_ticks  = csr_wdata;
            CSR_ABORT: cfg_in.abort_ticks = csr_wdata;
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_ticks  <= HOLD_RESET;
         cfg_ff.step_ticks  <= STEP_RESET;
         cfg_ff.abort_ticks <= ABORT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/bhm_core.sv =====
`timescale 1ns / 1ps
module bhm_core #(
   parameter int MODELS     = 7,
   parameter int TIMER_BITS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  button,
   input  bhm_pkg::cfg_type      cfg,
   output bhm_pkg::result_type   result
);
   import bhm_pkg::*;

   localparam int CMP_BITS = (TIMER_BITS > REG_BITS) ? TIMER_BITS : REG_BITS;

   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_HOLD    = 3'd1;
   localparam logic [2:0] PH_MENU    = 3'd2;
   localparam logic [2:0] PH_CONFIRM = 3'd3;
   localparam logic [2:0] PH_SECOND  = 3'd4;

   logic [2:0]            phase_ff, phase_in;
   logic [TIMER_BITS-1:0] elapsed_ff, elapsed_in;
   logic [INDEX_BITS-1:0] index_ff, index_in;
   logic                  pipe_ff, pipe_in;

   logic [TIMER_BITS-1:0] elapsed_inc;
   logic [INDEX_BITS-1:0] index_step;
   logic                  hold_over, step_over, abort_over;
   result_type            res;

   assign elapsed_inc = (&elapsed_ff) ? elapsed_ff : elapsed_ff + 1'b1;
   assign hold_over  = CMP_BITS'(elapsed_inc) > CMP_BITS'(cfg.hold_ticks);
   assign step_over  = CMP_BITS'(elapsed_inc) > CMP_BITS'(cfg.step_ticks);
   assign abort_over = CMP_BITS'(elapsed_inc) > CMP_BITS'(cfg.abort_ticks);

   always_comb begin
      index_step = index_ff + 1'b1;
      if (index_step > INDEX_BITS'(MODELS)) index_step = '0;
   end

   always_comb begin
      phase_in   = phase_ff;
      elapsed_in = elapsed_inc;
      index_in   = index_ff;
      pipe_in    = pipe_ff;
      res.led_write   = pipe_ff;
      res.led_color   = pipe_ff ? COLOR_BLUE : COLOR_OFF;
      res.flash_count = FLASH_NONE;
      res.awb_cmd     = AWB_NONE;
      unique case (phase_ff)
         PH_IDLE: begin
            if (button) begin
               elapsed_in = '0;
               phase_in   = PH_HOLD;
            end
         end
         PH_HOLD: begin
            if (!button) begin
               phase_in = PH_IDLE;
            end else if (hold_over) begin
               index_in      = '0;
               elapsed_in    = '0;
               res.led_write = 1'b1;
               res.led_color = index_color('0);
               phase_in      = PH_MENU;
            end
         end
         PH_MENU: begin
            if (!button) begin
               res.flash_count = FLASH_CONFIRM;
               res.led_write   = 1'b1;
               res.led_color   = index_color(index_ff);
               elapsed_in      = '0;
               if (index_ff == '0) res.awb_cmd = AWB_ENABLE;
               else pipe_in = 1'b1;
               phase_in = PH_CONFIRM;
            end else if (step_over) begin
               elapsed_in    = '0;
               index_in      = index_step;
               res.led_write = 1'b1;
               res.led_color = index_color(index_step);
            end
         end
         PH_CONFIRM: begin
            if (button) begin
               elapsed_in = '0;
               phase_in   = PH_SECOND;
            end else if (abort_over) begin
               pipe_in       = 1'b0;
               res.led_write = 1'b1;
               res.led_color = COLOR_OFF;
               phase_in      = PH_IDLE;
            end
         end
         PH_SECOND: begin
            if (!button) begin
               if (index_ff == '0) res.awb_cmd = AWB_DISABLE;
               res.flash_count = FLASH_FINISH;
               pipe_in         = 1'b0;
               res.led_write   = 1'b1;
               res.led_color   = COLOR_OFF;
               phase_in        = PH_IDLE;
            end else if (hold_over) begin
               pipe_in       = 1'b0;
               res.led_write = 1'b1;
               res.led_color = COLOR_OFF;
               phase_in      = PH_IDLE;
            end
         end
         default: begin
            pipe_in       = 1'b0;
            res.led_write = 1'b1;
            res.led_color = COLOR_OFF;
            phase_in      = PH_IDLE;
         end
      endcase
      res.pipe_active = pipe_in;
      res.menu_index  = index_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         elapsed_ff <= '0;
         index_ff   <= '0;
         pipe_ff    <= 1'b0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         elapsed_ff <= elapsed_in;
         index_ff   <= index_in;
         pipe_ff    <= pipe_in;
      end
   end

   assign result = res;

endmodule

// ===== rtl/button_hold_menu_controller_unit.sv =====
`timescale 1ns / 1ps
// channel   dir  handshake              payload
// req       in   req_tvalid/req_tready  req_tdata[0] button
// rsp       out  rsp_tvalid/rsp_tready  rsp_tdata result fields
// csr       in   csr_we                 csr_index, csr_wdata
// one beat per cycle sustained while rsp_tready is high; an accepted beat passes
// through the input register and then the output register before it appears on rsp
// the phase machine and timer compare sit between the input and output registers
// reset is synchronous and restores the register defaults and the idle phase
// a stalled rsp holds its beat while one more req beat waits in the input register
module button_hold_menu_controller_unit #(
   parameter int MODELS     = 7,
   parameter int TIMER_BITS = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [0] button, [7:1] zero
   input  logic [bhm_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] led_write, [24:1] led_color, [27:25] flash_count, [29:28] awb_cmd,
   // [30] pipe_active, [33:31] menu_index, [39:34] zero
   output logic [bhm_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input  logic                                csr_we,
   input  logic [bhm_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [bhm_pkg::REG_BITS-1:0]        csr_wdata
);
   import bhm_pkg::*;

   cfg_type    cfg;
   result_type result;

   logic       in_valid_ff, in_valid_in;
   logic       in_button_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_data_ff;
   logic       advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   bhm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bhm_core #(
      .MODELS     (MODELS),
      .TIMER_BITS (TIMER_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .button  (in_button_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) in_button_ff <= req_tdata[0];
      if (advance) out_data_ff <= result;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS - $bits(result_type)){1'b0}}, out_data_ff};

`ifndef NO_ASSERTIONS
   a_color_off_without_write: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[24:1] == '0)
      else $error("led color set without a write");

   a_flash_writes_led: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[27:25] != FLASH_NONE |-> rsp_tdata[0])
      else $error("flash request without led write");

   a_awb_enable_no_pipe: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[29:28] == AWB_ENABLE |-> !rsp_tdata[30] && rsp_tdata[0])
      else $error("white balance enable with pipe flag set");

   a_awb_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[29:28] != AWB_NONE |-> rsp_tdata[33:31] == '0)
      else $error("white balance command with nonzero index");
`endif

endmodule
